// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an implication holds on every rising clock edge outside reset.
`define DBF_ASSERT_IMPL(label, cond, prop, msg) \
  `DBF_ASSERT(label, (cond) |-> (prop), msg)

`endif

// File: rtl/dbf_pkg.sv
// Shared types and constants of the duplicate bundle filter.
package dbf_pkg;

  localparam int TableDepthDefault = 8;
  localparam int WordW             = 32;
  localparam int HeldW             = 4;
  localparam int QueueDepth        = 2;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef struct packed {
    logic [WordW-1:0] source_node;
    logic [WordW-1:0] time_word_first;
    logic [WordW-1:0] time_word_second;
    logic [WordW-1:0] frag_offset;
    logic [WordW-1:0] total_length;
  } ident_t;

  typedef struct packed {
    op_e    op;
    ident_t ident;
  } item_t;

endpackage

// File: rtl/duplicate_bundle_filter_unit.sv
// Top level of the duplicate bundle filter.
// A record item (command 0) appends the bundle identity to a circular table of
// TableDepth entries, dropping the oldest entry and flagging evicted_oldest when
// the table is full; a check item (command 1) reports already_seen when any held
// entry matches all five identity words. Every item gives exactly one result,
// which also carries the entry count after the item (four bits, wrapping above
// fifteen). The block takes one item per cycle when the result side does not
// stall; each result passes through the input register and the two-entry queue,
// and the table stage compares all entries in parallel and registers the result.
module duplicate_bundle_filter_unit
  import dbf_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [WordW-1:0] source_node_i,
  input  logic [WordW-1:0] time_word_first_i,
  input  logic [WordW-1:0] time_word_second_i,
  input  logic [WordW-1:0] frag_offset_i,
  input  logic [WordW-1:0] total_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             already_seen_o,
  output logic             evicted_oldest_o,
  output logic [HeldW-1:0] entries_held_o
);

  item_t front_item;
  item_t pop_item;
  logic  push_valid;
  logic  push_ready;
  logic  pop_valid;
  logic  pop_ready;

  dbf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .source_node_i      (source_node_i),
    .time_word_first_i  (time_word_first_i),
    .time_word_second_i (time_word_second_i),
    .frag_offset_i      (frag_offset_i),
    .total_length_i     (total_length_i),
    .item_o             (front_item),
    .push_ready_i       (push_ready),
    .push_valid_o       (push_valid)
  );

  dbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  dbf_table #(
    .TableDepth (TableDepth)
  ) u_table (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .already_seen_o   (already_seen_o),
    .evicted_oldest_o (evicted_oldest_o),
    .entries_held_o   (entries_held_o)
  );

endmodule

// File: rtl/dbf_front.sv
// Front stage: accepts input items, decodes the command and feeds the queue.
module dbf_front
  import dbf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [WordW-1:0] source_node_i,
  input  logic [WordW-1:0] time_word_first_i,
  input  logic [WordW-1:0] time_word_second_i,
  input  logic [WordW-1:0] frag_offset_i,
  input  logic [WordW-1:0] total_length_i,
  output item_t            item_o,
  input  logic             push_ready_i,
  output logic             push_valid_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;
  logic  push;

  assign push       = valid_q && push_ready_i;
  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op                     <= op_e'(command_i);
      item_q.ident.source_node      <= source_node_i;
      item_q.ident.time_word_first  <= time_word_first_i;
      item_q.ident.time_word_second <= time_word_second_i;
      item_q.ident.frag_offset      <= frag_offset_i;
      item_q.ident.total_length     <= total_length_i;
    end
  end

  assign item_o       = item_q;
  assign push_valid_o = valid_q;

endmodule

// File: rtl/dbf_queue.sv
// Short queue between the front stage and the table stage.
module dbf_queue
  import dbf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            slots_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/dbf_table.sv
// Table stage: circular identity table, parallel match and result register.
module dbf_table
  import dbf_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  item_t            pop_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             already_seen_o,
  output logic             evicted_oldest_o,
  output logic [HeldW-1:0] entries_held_o
);

  localparam int SlotW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int SumW   = CountW + 1;
  localparam logic [SumW-1:0]   DepthS = SumW'(TableDepth);
  localparam logic [CountW-1:0] DepthC = CountW'(TableDepth);

  ident_t              table_q [TableDepth];
  logic [SlotW-1:0]    oldest_q, oldest_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic                seen_q, evict_q;
  logic [HeldW-1:0]    held_q;
  logic                exec;
  logic                is_record;
  logic                full;
  logic [SumW-1:0]     tail_sum;
  logic [SumW-1:0]     tail_wrap;
  logic [SumW-1:0]     oldest_inc;
  logic [SlotW-1:0]    wr_slot;
  logic [TableDepth-1:0] hit_vec;
  logic                seen_d, evict_d;
  logic [CountW+HeldW-1:0] held_ext;

  assign pop_ready_o = !out_valid_q || !out_stall_i;
  assign exec        = pop_valid_i && pop_ready_o;
  assign is_record   = pop_item_i.op == OP_RECORD;
  assign full        = count_q == DepthC;

  assign tail_sum   = SumW'(oldest_q) + SumW'(count_q);
  assign tail_wrap  = (tail_sum >= DepthS) ? tail_sum - DepthS : tail_sum;
  assign oldest_inc = SumW'(oldest_q) + SumW'(1);
  assign wr_slot    = full ? oldest_q : tail_wrap[SlotW-1:0];

  for (genvar i = 0; i < TableDepth; i++) begin : g_match
    logic [SumW-1:0] age;
    always_comb begin
      if (SumW'(i) >= SumW'(oldest_q)) begin
        age = SumW'(i) - SumW'(oldest_q);
      end else begin
        age = SumW'(i) + DepthS - SumW'(oldest_q);
      end
    end
    assign hit_vec[i] = (age < SumW'(count_q)) && (table_q[i] == pop_item_i.ident);
  end

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    seen_d   = 1'b0;
    evict_d  = 1'b0;
    if (is_record) begin
      if (full) begin
        evict_d  = 1'b1;
        oldest_d = (oldest_inc >= DepthS) ? '0 : oldest_inc[SlotW-1:0];
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      seen_d = |hit_vec;
    end
  end

  assign held_ext = (CountW + HeldW)'(count_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (exec) begin
        oldest_q <= oldest_d;
        count_q  <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && is_record) begin
      table_q[wr_slot] <= pop_item_i.ident;
    end
    if (exec) begin
      seen_q  <= seen_d;
      evict_q <= evict_d;
      held_q  <= held_ext[HeldW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign already_seen_o   = seen_q;
  assign evicted_oldest_o = evict_q;
  assign entries_held_o   = held_q;

endmodule

// File: rtl/dbf_checker.sv
// Port-level checker of the duplicate bundle filter and its bind.
`include "assert_macros.svh"

module dbf_checker
  import dbf_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             already_seen_o,
  input logic             evicted_oldest_o,
  input logic [HeldW-1:0] entries_held_o
);

  logic res_any;
  assign res_any = already_seen_o | evicted_oldest_o | in_valid_i | in_stall_o;

  `DBF_ASSERT_IMPL(a_out_hold, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(entries_held_o) && $stable(already_seen_o) && $stable(evicted_oldest_o)), "stalled result changed")
  `DBF_ASSERT_IMPL(a_evict_no_seen, out_valid_o && evicted_oldest_o, !already_seen_o || !res_any, "eviction reported on a check")
  `DBF_ASSERT_IMPL(a_seen_nonempty, out_valid_o && already_seen_o, (TableDepth > 15) || (entries_held_o != '0), "match reported on empty table")
  `DBF_ASSERT_IMPL(a_held_bound, out_valid_o, (TableDepth > 15) || (32'(entries_held_o) <= TableDepth), "entry count above table depth")

endmodule

bind duplicate_bundle_filter_unit dbf_checker #(
  .TableDepth (TableDepth)
) u_dbf_checker (.*);
